### rtl/rfat_pkg.sv
`default_nettype none

package rfat_pkg;

    localparam int NUM_REGS = 32;
    localparam int TAG_BITS = 4;
    localparam int IDX_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_RENAME = 3'd1;
    localparam logic [2:0] OP_COMMIT = 3'd2;
    localparam logic [2:0] OP_FLUSH  = 3'd3;
    localparam logic [2:0] OP_LOAD   = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic [7:0]         reg_index;
        logic [3:0]         rob_tag;
        logic signed [31:0] write_value;
    } t_in_word;

    typedef struct packed {
        logic               index_ok;
        logic               source_pending;
        logic [3:0]         source_tag;
        logic signed [31:0] source_value;
    } t_out_word;

    // one operation presented to the register store
    typedef struct packed {
        logic                apply;
        logic                in_range;
        logic [2:0]          operation;
        logic [IDX_BITS-1:0] idx;
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         value;
    } t_reg_cmd;

    typedef struct packed {
        logic                pending;
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         value;
    } t_reg_rd;

endpackage

`default_nettype wire

### rtl/register_file_alias_table.sv
`default_nettype none

// Register file with alias table: value, pending flag and reorder-buffer tag
// per register. One operation word per input handshake (read, rename,
// commit, flush, load); only a read produces an output word.
// Input channel: i_in_valid / o_in_ready / i_in_word. Output channel:
// o_out_valid / i_out_ready / o_out_word.
// The input word is registered; the operation is applied to the register store
// at the clock edge at which it leaves the input register, and a read result is
// captured in the output register at that same edge.
// Throughput is one operation per cycle, except while a read waits behind a
// full output register.
// Updates take effect in acceptance order: a read sees all earlier writes.
// While the receiver stalls, the held result waits in the output register
// and one further operation can be taken into the input register; a read
// waiting behind a full output register stops further acceptance, other
// operations still drain.
// Reset (synchronous, active low) empties both registers, clears every
// pending flag and makes every register read as zero.

module register_file_alias_table
    import rfat_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_word,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_word     o_out_word
);

    logic      r_s1_v;
    t_in_word  r_s1;
    logic      r_out_v;
    t_out_word r_out;

    logic      s1_read;
    logic      s1_ok;
    logic      s1_adv;
    logic      out_free;
    t_reg_cmd  cmd;
    t_reg_rd   rd;
    t_out_word n_out;

    assign s1_read  = (r_s1.operation == OP_READ);
    assign s1_ok    = ({1'b0, r_s1.reg_index} < 9'(NUM_REGS));
    assign out_free = !r_out_v || i_out_ready;
    assign s1_adv   = r_s1_v && (!s1_read || out_free);

    assign o_in_ready = !r_s1_v || s1_adv;

    assign cmd.apply     = s1_adv;
    assign cmd.in_range  = s1_ok;
    assign cmd.operation = r_s1.operation;
    assign cmd.idx       = r_s1.reg_index[IDX_BITS-1:0];
    assign cmd.tag       = TAG_BITS'(r_s1.rob_tag);
    assign cmd.value     = r_s1.write_value;

    rfat_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_rd    (rd)
    );

    always_comb begin
        n_out = '0;
        n_out.index_ok = s1_ok;
        if (s1_ok) begin
            if (rd.pending) begin
                n_out.source_pending = 1'b1;
                n_out.source_tag     = 4'(rd.tag);
            end else begin
                n_out.source_value = rd.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_v <= i_in_valid;
            end
            if (s1_adv && s1_read) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in_word;
        end
        if (s1_adv && s1_read) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

### rtl/rfat_regs.sv
`default_nettype none

module rfat_regs
    import rfat_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_reg_cmd i_cmd,
    output t_reg_rd       o_rd
);

    logic [31:0]         r_values  [NUM_REGS];
    logic [TAG_BITS-1:0] r_tags    [NUM_REGS];
    logic [NUM_REGS-1:0] r_pending;
    logic [NUM_REGS-1:0] r_written;   // clear: value reads as zero

    logic do_idx;

    assign do_idx = i_cmd.apply && i_cmd.in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_written <= '0;
        end else if (i_cmd.apply) begin
            unique case (i_cmd.operation)
                OP_RENAME: begin
                    if (i_cmd.in_range) begin
                        r_pending[i_cmd.idx] <= 1'b1;
                    end
                end
                OP_COMMIT: begin
                    if (i_cmd.in_range) begin
                        r_written[i_cmd.idx] <= 1'b1;
                        if (r_pending[i_cmd.idx] && (r_tags[i_cmd.idx] == i_cmd.tag)) begin
                            r_pending[i_cmd.idx] <= 1'b0;
                        end
                    end
                end
                OP_FLUSH: begin
                    r_pending <= '0;
                end
                OP_LOAD: begin
                    if (i_cmd.in_range) begin
                        r_written[i_cmd.idx] <= 1'b1;
                        r_pending[i_cmd.idx] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_idx) begin
            if (i_cmd.operation == OP_RENAME) begin
                r_tags[i_cmd.idx] <= i_cmd.tag;
            end
            if ((i_cmd.operation == OP_COMMIT) || (i_cmd.operation == OP_LOAD)) begin
                r_values[i_cmd.idx] <= i_cmd.value;
            end
        end
    end

    assign o_rd.pending = r_pending[i_cmd.idx];
    assign o_rd.tag     = r_tags[i_cmd.idx];
    assign o_rd.value   = r_written[i_cmd.idx] ? r_values[i_cmd.idx] : 32'd0;

endmodule

`default_nettype wire
